/* rtl/chbd_pkg.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared constants, phase codes, status codes and word types of the HTTP
// chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

   localparam int SIZE_BITS_DEF = 24;
   localparam int FIFO_DEPTH    = 4;
   localparam int PTR_W         = $clog2(FIFO_DEPTH);
   localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] PH_LEAD     = 3'd0;
   localparam logic [2:0] PH_DIGITS   = 3'd1;
   localparam logic [2:0] PH_EXT      = 3'd2;
   localparam logic [2:0] PH_SIZE_LF  = 3'd3;
   localparam logic [2:0] PH_DATA     = 3'd4;
   localparam logic [2:0] PH_TRAIL_CR = 3'd5;
   localparam logic [2:0] PH_TRAIL_LF = 3'd6;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [1:0] ST_PAYLOAD  = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_TRUNC    = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
   } chbd_word_type;

   typedef struct packed {
      logic [1:0]    count;
      chbd_word_type word0;
      chbd_word_type word1;
   } chbd_emit_type;

endpackage

/* rtl/chbd_if.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder channels
// Valid/ready channels for the raw body bytes and for the decoded words.
// ----------------------------------------------------------------------------
interface chbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface chbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] status;

   modport source (output valid, output out_byte, output status, input ready);
   modport sink (input valid, input out_byte, input status, output ready);
endinterface

/* rtl/chbd_step.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder step logic
// Computes the next parser state and the words caused by one body byte.
// ----------------------------------------------------------------------------
module chbd_step #(
   parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
   input  logic [7:0]            in_byte,
   input  logic                  end_of_input,
   input  logic [2:0]            cur_phase,
   input  logic [SIZE_BITS-1:0]  cur_accum,
   input  logic [SIZE_BITS-1:0]  cur_left,
   input  logic                  cur_digit,
   input  logic                  cur_finished,
   output logic [2:0]            nxt_phase,
   output logic [SIZE_BITS-1:0]  nxt_accum,
   output logic [SIZE_BITS-1:0]  nxt_left,
   output logic                  nxt_digit,
   output logic                  nxt_finished,
   output chbd_pkg::chbd_emit_type emit
);
   import chbd_pkg::*;

   logic [2:0]           eff_phase;
   logic                 used;
   logic                 is_hex;
   logic                 is_blank;
   logic [3:0]           hex_val;
   logic                 accum_sat;
   logic [SIZE_BITS-1:0] left_dec;
   logic                 first_vld;
   chbd_word_type        first_word;
   logic                 trunc;
   chbd_word_type        trunc_word;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte inside {[8'h61:8'h66]}) begin
         hex_val = 4'(in_byte - 8'h57);
      end else if (in_byte inside {[8'h41:8'h46]}) begin
         hex_val = 4'(in_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_blank  = in_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C};
   assign accum_sat = |cur_accum[SIZE_BITS-1 -: 4];
   assign left_dec  = (cur_left != '0) ? cur_left - SIZE_BITS'(1) : cur_left;

   always_comb begin
      eff_phase    = (cur_phase > PH_TRAIL_LF) ? PH_LEAD : cur_phase;
      used         = 1'b0;
      nxt_phase    = cur_phase;
      nxt_accum    = cur_accum;
      nxt_left     = cur_left;
      nxt_digit    = cur_digit;
      nxt_finished = cur_finished;
      first_vld    = 1'b0;
      first_word   = '{out_byte: 8'h00, status: ST_PAYLOAD};

      if (!cur_finished) begin
         case (eff_phase)
            PH_SIZE_LF: begin
               if (in_byte == CH_LF) begin
                  nxt_phase = PH_DATA;
                  used      = 1'b1;
               end else begin
                  eff_phase = PH_DATA;
               end
            end
            PH_TRAIL_CR: begin
               if (in_byte == CH_CR) begin
                  nxt_phase = PH_TRAIL_LF;
                  used      = 1'b1;
               end else if (in_byte == CH_LF) begin
                  nxt_phase = PH_LEAD;
                  used      = 1'b1;
               end else begin
                  eff_phase = PH_LEAD;
               end
            end
            PH_TRAIL_LF: begin
               if (in_byte == CH_LF) begin
                  nxt_phase = PH_LEAD;
                  used      = 1'b1;
               end else begin
                  eff_phase = PH_LEAD;
               end
            end
            default: begin
            end
         endcase

         if (!used) begin
            nxt_phase = eff_phase;
            if (eff_phase == PH_DATA) begin
               first_vld  = 1'b1;
               first_word = '{out_byte: in_byte, status: ST_PAYLOAD};
               nxt_left   = left_dec;
               nxt_phase  = (left_dec == '0) ? PH_TRAIL_CR : PH_DATA;
            end else if (in_byte == CH_CR || in_byte == CH_LF) begin
               if (!cur_digit || cur_accum == '0) begin
                  nxt_finished = 1'b1;
                  first_vld    = 1'b1;
                  first_word   = '{out_byte: 8'h00, status: ST_COMPLETE};
               end else begin
                  nxt_left  = cur_accum;
                  nxt_phase = (in_byte == CH_CR) ? PH_SIZE_LF : PH_DATA;
               end
               nxt_accum = '0;
               nxt_digit = 1'b0;
            end else if (eff_phase == PH_LEAD && is_blank) begin
               nxt_phase = PH_LEAD;
            end else if (eff_phase != PH_EXT && is_hex) begin
               nxt_accum = accum_sat ? '1 : {cur_accum[SIZE_BITS-5:0], hex_val};
               nxt_digit = 1'b1;
               nxt_phase = PH_DIGITS;
            end else begin
               nxt_phase = PH_EXT;
            end
         end
      end

      trunc      = end_of_input && !nxt_finished;
      trunc_word = '{out_byte: 8'h00, status: ST_TRUNC};

      if (end_of_input) begin
         nxt_phase    = PH_LEAD;
         nxt_accum    = '0;
         nxt_left     = '0;
         nxt_digit    = 1'b0;
         nxt_finished = 1'b0;
      end

      emit.count = 2'(first_vld) + 2'(trunc);
      emit.word0 = first_vld ? first_word : trunc_word;
      emit.word1 = trunc_word;
   end

endmodule

/* rtl/chbd_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder result queue
// Small queue that takes up to two words per cycle and drives the result
// channel one word per cycle while rsp.ready is high.
// ----------------------------------------------------------------------------
module chbd_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  chbd_pkg::chbd_emit_type push,
   output logic                    room,
   chbd_rsp_if.source              rsp
);
   import chbd_pkg::*;

   chbd_word_type    mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pop;
   chbd_word_type    head;

   assign pop       = rsp.valid && rsp.ready;
   assign head      = mem_ff[rd_ptr_ff];
   assign rsp.valid = count_ff != '0;
   assign rsp.out_byte = head.out_byte;
   assign rsp.status   = head.status;
   assign room      = count_ff <= CNT_W'(FIFO_DEPTH - 2);

   assign wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(push.count));
   assign rd_ptr_in = PTR_W'(rd_ptr_ff + PTR_W'(pop));
   assign count_in  = CNT_W'(count_ff + CNT_W'(push.count) - CNT_W'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.word1;
      end
   end

endmodule

/* rtl/http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Parses a chunked transfer body byte by byte and delivers the payload
// bytes, a completion word and a truncation word.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake    Word
//  req      in   valid/ready  in_byte[7:0], end_of_input
//  rsp      out  valid/ready  out_byte[7:0], status[1:0]
//
// One body byte is accepted per cycle while req.ready is high; rsp is registered.
// A byte can cause two words, which a four-word queue absorbs; req.ready is low
// while the queue has fewer than two free places, so a stall on rsp stalls req.
// Reset is synchronous and puts the parser at the start of a size line.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
   parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   chbd_req_if.sink   req_chan,
   chbd_rsp_if.source rsp_chan
);
   import chbd_pkg::*;

   logic [2:0]           phase_ff;
   logic [2:0]           phase_in;
   logic [SIZE_BITS-1:0] accum_ff;
   logic [SIZE_BITS-1:0] accum_in;
   logic [SIZE_BITS-1:0] left_ff;
   logic [SIZE_BITS-1:0] left_in;
   logic                 digit_ff;
   logic                 digit_in;
   logic                 finished_ff;
   logic                 finished_in;
   logic                 accept;
   logic                 room;
   chbd_emit_type        emit;
   chbd_emit_type        push;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   chbd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .cur_phase    (phase_ff),
      .cur_accum    (accum_ff),
      .cur_left     (left_ff),
      .cur_digit    (digit_ff),
      .cur_finished (finished_ff),
      .nxt_phase    (phase_in),
      .nxt_accum    (accum_in),
      .nxt_left     (left_in),
      .nxt_digit    (digit_in),
      .nxt_finished (finished_in),
      .emit         (emit)
   );

   always_comb begin
      push = emit;
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   chbd_rsp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEAD;
         accum_ff    <= '0;
         left_ff     <= '0;
         digit_ff    <= 1'b0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         left_ff     <= left_in;
         digit_ff    <= digit_in;
         finished_ff <= finished_in;
      end
   end

endmodule

/* tb/tb_http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Feeds chunked bodies to the decoder one byte at a time: a few hand-written
// bodies, then random well-formed, broken, noisy and full-rate bodies, with
// random gaps on the request side and random stalls on the result side. A
// predictor of the parser computes the words each byte should produce, and
// every result word is compared with the oldest word still due.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;

   import chbd_pkg::*;

   localparam int SZ          = SIZE_BITS_DEF;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock;
   logic reset;

   chbd_req_if req_chan();
   chbd_rsp_if rsp_chan();

   http_chunked_body_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parser state as the decoder should hold it.
   logic [2:0]    dec_phase  = PH_LEAD;
   logic [SZ-1:0] size_acc   = '0;
   logic [SZ-1:0] chunk_left = '0;
   logic          digit_seen = 1'b0;
   logic          body_done  = 1'b0;

   chbd_word_type expected_words[$];
   logic [7:0]    body_q[$];

   bit calm           = 1'b0;
   int stall_left     = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int parsed_bytes   = 0;
   int bodies_sent    = 0;
   int payload_words  = 0;
   int complete_words = 0;
   int trunc_words    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(input int nib);
      if (nib < 10) return 8'(8'h30 + nib);
      if ($urandom_range(0, 1) == 1) return 8'(8'h41 + nib - 10);
      return 8'(8'h61 + nib - 10);
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   task automatic add_body_byte(input logic [7:0] b);
      body_q = {body_q, b};
   endtask

   task automatic add_expected(input chbd_word_type w);
      expected_words = {expected_words, w};
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] %s", $time, what);
   endtask

   // Works out the words that one accepted byte causes.
   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic [2:0] p;
      logic       used;
      int         digit;
      if (!body_done) begin
         parsed_bytes++;
         p    = (dec_phase > PH_TRAIL_LF) ? PH_LEAD : dec_phase;
         used = 1'b0;
         if (p == PH_SIZE_LF) begin
            if (b == CH_LF) begin
               dec_phase = PH_DATA;
               used      = 1'b1;
            end else p = PH_DATA;
         end else if (p == PH_TRAIL_CR) begin
            if (b == CH_CR) begin
               dec_phase = PH_TRAIL_LF;
               used      = 1'b1;
            end else if (b == CH_LF) begin
               dec_phase = PH_LEAD;
               used      = 1'b1;
            end else p = PH_LEAD;
         end else if (p == PH_TRAIL_LF) begin
            if (b == CH_LF) begin
               dec_phase = PH_LEAD;
               used      = 1'b1;
            end else p = PH_LEAD;
         end
         if (b >= "0" && b <= "9") digit = int'(b - "0");
         else if (b >= "a" && b <= "f") digit = int'(b - "a") + 10;
         else if (b >= "A" && b <= "F") digit = int'(b - "A") + 10;
         else digit = -1;
         if (!used) begin
            dec_phase = p;
            if (p == PH_DATA) begin
               add_expected(chbd_word_type'{out_byte: b, status: ST_PAYLOAD});
               if (chunk_left != '0) chunk_left--;
               dec_phase = (chunk_left == '0) ? PH_TRAIL_CR : PH_DATA;
            end else if (b == CH_CR || b == CH_LF) begin
               if (!digit_seen || size_acc == '0) begin
                  body_done = 1'b1;
                  add_expected(chbd_word_type'{out_byte: 8'h00, status: ST_COMPLETE});
               end else begin
                  chunk_left = size_acc;
                  dec_phase  = (b == CH_CR) ? PH_SIZE_LF : PH_DATA;
               end
               size_acc   = '0;
               digit_seen = 1'b0;
            end else if (p == PH_LEAD && (b == 8'h20 || b == 8'h09 || b == 8'h0B ||
                                          b == 8'h0C)) begin
            end else if (p != PH_EXT && digit >= 0) begin
               if (size_acc > ({SZ{1'b1}} >> 4)) size_acc = '1;
               else size_acc = {size_acc[SZ-5:0], 4'(digit)};
               digit_seen = 1'b1;
               dec_phase  = PH_DIGITS;
            end else begin
               dec_phase = PH_EXT;
            end
         end
      end
      if (last) begin
         if (!body_done)
            add_expected(chbd_word_type'{out_byte: 8'h00, status: ST_TRUNC});
         dec_phase  = PH_LEAD;
         size_acc   = '0;
         chunk_left = '0;
         digit_seen = 1'b0;
         body_done  = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.in_byte      <= b;
      req_chan.end_of_input <= last;
      do @(posedge clock); while (!req_chan.ready);
      predict_byte(b, last);
   endtask

   task automatic send_text(input string s, input bit mark_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], mark_last && i == s.len() - 1);
   endtask

   task automatic send_body();
      foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1);
      bodies_sent++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic build_body(input bit broken);
      int         n_chunks;
      int         size;
      int         left;
      int         cut;
      int         mode;
      logic [7:0] ch;
      logic [7:0] digits[$];
      body_q.delete();
      n_chunks = $urandom_range(0, 3);
      for (int c = 0; c <= n_chunks; c++) begin
         size = 0;
         if (c < n_chunks) begin
            mode = $urandom_range(0, 19);
            if (mode < 15) size = $urandom_range(1, 12);
            else if (mode < 19) size = $urandom_range(13, 40);
            else size = $urandom_range(41, 200);
         end
         repeat ($urandom_range(0, 2)) add_body_byte(blank_byte());
         if (c < n_chunks || $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(0, 2)) add_body_byte("0");
            left = size;
            digits.delete();
            do begin
               digits.push_front(hex_char(left % 16));
               left = left / 16;
            end while (left != 0);
            foreach (digits[i]) add_body_byte(digits[i]);
         end
         if ($urandom_range(0, 4) == 0) begin
            add_body_byte(";");
            repeat ($urandom_range(0, 4)) begin
               do ch = 8'($urandom_range(0, 255)); while (ch == CH_CR || ch == CH_LF);
               add_body_byte(ch);
            end
         end
         case ($urandom_range(0, 5))
            0: add_body_byte(CH_LF);
            1: add_body_byte(CH_CR);
            default: begin
               add_body_byte(CH_CR);
               add_body_byte(CH_LF);
            end
         endcase
         if (c < n_chunks) begin
            repeat (size) add_body_byte(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
               0: ;
               1: add_body_byte(CH_CR);
               2: add_body_byte(CH_LF);
               default: begin
                  add_body_byte(CH_CR);
                  add_body_byte(CH_LF);
               end
            endcase
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         add_body_byte(CH_CR);
         add_body_byte(CH_LF);
      end
      if (broken) begin
         mode = $urandom_range(0, 2);
         if (mode == 0 && body_q.size() > 1) begin
            cut = $urandom_range(1, body_q.size() - 1);
            while (body_q.size() > cut) void'(body_q.pop_back());
         end else if (mode == 1) begin
            body_q.delete();
            add_body_byte("F");
            repeat ($urandom_range(5, 8)) add_body_byte(hex_char($urandom_range(0, 15)));
            if ($urandom_range(0, 1) == 1) add_body_byte(CH_CR);
            add_body_byte(CH_LF);
            repeat ($urandom_range(0, 6)) add_body_byte(8'($urandom_range(0, 255)));
         end else begin
            body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end
   endtask

   // Blanks, extension, full CR LF framing, empty closing line, ignored tail byte;
   // bare CR before data, missing trailer, 0x prefix; size overflow and truncation.
   task automatic test_directed();
      send_text(" \0133;\015\nabc\015\n\t\nZ", 1'b1);
      send_text("2\015AB0x\015", 1'b1);
      send_text("\014FFFFFFF\n", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_results();
   endtask

   task automatic test_wellformed_bodies();
      int goal;
      goal = parsed_bytes + 650;
      while (parsed_bytes < goal) begin
         calm = ($urandom_range(0, 4) == 0);
         build_body(1'b0);
         send_body();
         if ($urandom_range(0, 7) == 0) drain_results();
      end
      calm = 1'b0;
      drain_results();
   endtask

   task automatic test_broken_bodies();
      int goal;
      goal = parsed_bytes + 250;
      while (parsed_bytes < goal) begin
         build_body(1'b1);
         send_body();
      end
      drain_results();
   endtask

   task automatic test_noise_bytes();
      int         goal;
      logic [7:0] ch;
      goal = parsed_bytes + 120;
      while (parsed_bytes < goal) begin
         body_q.delete();
         repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 5))
               0: ch = CH_CR;
               1: ch = CH_LF;
               2: ch = blank_byte();
               3: ch = hex_char($urandom_range(0, 15));
               default: ch = 8'($urandom_range(0, 255));
            endcase
            add_body_byte(ch);
         end
         send_body();
      end
      drain_results();
   endtask

   task automatic test_full_rate();
      int goal;
      goal = parsed_bytes + 180;
      calm = 1'b1;
      while (parsed_bytes < goal) begin
         build_body($urandom_range(0, 3) == 0);
         send_body();
      end
      calm = 1'b0;
      drain_results();
   endtask

   initial begin : result_stall
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            stall_left = 0;
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_chan.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   initial begin : word_check
      chbd_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               note_mismatch($sformatf("unexpected word: out_byte=%02h status=%0d",
                                       rsp_chan.out_byte, rsp_chan.status));
            end else begin
               want = expected_words.pop_front();
               if (rsp_chan.out_byte !== want.out_byte || rsp_chan.status !== want.status)
                  note_mismatch($sformatf(
                     {"word mismatch: expected out_byte=%02h status=%0d, ",
                      "got out_byte=%02h status=%0d"},
                     want.out_byte, want.status, rsp_chan.out_byte, rsp_chan.status));
               case (want.status)
                  ST_PAYLOAD: payload_words++;
                  ST_COMPLETE: complete_words++;
                  default: trunc_words++;
               endcase
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d words still due", cycle_count,
               expected_words.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.in_byte      <= 8'h00;
      req_chan.end_of_input <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_wellformed_bodies();
      test_broken_bodies();
      test_noise_bytes();
      test_full_rate();
      repeat (8) @(posedge clock);
      $display("Sent %0d bodies with %0d parsed bytes in %0d cycles.", bodies_sent,
               parsed_bytes, cycle_count);
      $display("Checked %0d payload words, %0d completions and %0d truncations.",
               payload_words, complete_words, trunc_words);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/chbd_pkg.sv
rtl/chbd_if.sv
rtl/chbd_step.sv
rtl/chbd_rsp_fifo.sv
rtl/http_chunked_body_decoder.sv
tb/tb_http_chunked_body_decoder.sv
